[src/bbt_pkg.sv]
// Shared types and constants for the bulk transfer tracker.
package bbt_pkg;

  localparam int COUNT_W = 32;
  localparam int BYTES_W = 40;
  localparam int TTIME_W = 48;
  localparam int LEN_W   = 16;
  localparam int RUNB_W  = 32;
  localparam int PKT_W   = 8;

  localparam int TOTALS_W = COUNT_W + COUNT_W + BYTES_W + TTIME_W;
  localparam int OUT_W    = 2 * TOTALS_W;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_BOUND   = 1'b1;

  localparam logic [31:0] TIMEOUT_RST = 32'd1000000;
  localparam logic [7:0]  BOUND_RST   = 8'd4;

  typedef struct packed {
    logic [31:0] timeout;
    logic [7:0]  bound;
  } bbt_cfg_t;

  typedef struct packed {
    logic [TTIME_W-1:0] time_us;
    logic [BYTES_W-1:0] bytes;
    logic [COUNT_W-1:0] packets;
    logic [COUNT_W-1:0] bulks;
  } bbt_totals_t;

endpackage

[src/bbt_in_reg.sv]
// Input register for one packet descriptor beat.
module bbt_in_reg #(
  parameter int TIME_BITS = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic                    drain,
  input  logic [TIME_BITS-1:0]    time_in,
  input  logic                    rev_in,
  input  logic [bbt_pkg::LEN_W-1:0] len_in,
  output logic                    valid,
  output logic [TIME_BITS-1:0]    time_q,
  output logic                    rev_q,
  output logic [bbt_pkg::LEN_W-1:0] len_q
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [TIME_BITS-1:0]      time_r;
  logic                      rev_r;
  logic [bbt_pkg::LEN_W-1:0] len_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      time_r <= time_in;
      rev_r  <= rev_in;
      len_r  <= len_in;
    end
  end

  assign valid  = valid_r;
  assign time_q = time_r;
  assign rev_q  = rev_r;
  assign len_q  = len_r;

endmodule

[src/bbt_dir_track.sv]
// Run tracking and saturating bulk totals for one direction.
module bbt_dir_track #(
  parameter int TIME_BITS = 48
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      upd,
  input  logic [TIME_BITS-1:0]      t,
  input  logic [bbt_pkg::LEN_W-1:0] len,
  input  logic [TIME_BITS-1:0]      other_last,
  input  bbt_pkg::bbt_cfg_t         cfg,
  output logic [TIME_BITS-1:0]      last_time,
  output bbt_pkg::bbt_totals_t      totals
);

  localparam int SUM_W = ((TIME_BITS > bbt_pkg::TTIME_W) ? TIME_BITS : bbt_pkg::TTIME_W) + 1;

  logic                        open_r, open_nxt;
  logic [TIME_BITS-1:0]        start_r, start_nxt;
  logic [TIME_BITS-1:0]        last_r, last_nxt;
  logic [bbt_pkg::PKT_W-1:0]   pkts_r, pkts_nxt;
  logic [bbt_pkg::RUNB_W-1:0]  bytes_r, bytes_nxt;
  bbt_pkg::bbt_totals_t        tot_r, tot_nxt;

  logic [TIME_BITS-1:0]        gap;
  logic [TIME_BITS-1:0]        span;
  logic                        restart;
  logic [bbt_pkg::PKT_W:0]     next_cnt;
  logic [bbt_pkg::RUNB_W:0]    bytes_sum;
  logic [bbt_pkg::RUNB_W-1:0]  bytes_run;
  logic                        at_bound;
  logic                        past_bound;
  logic [bbt_pkg::PKT_W:0]     add_pkts;
  logic [bbt_pkg::RUNB_W-1:0]  add_bytes;
  logic [TIME_BITS-1:0]        add_time;
  logic [bbt_pkg::COUNT_W:0]   cnt_sum;
  logic [bbt_pkg::COUNT_W:0]   pkt_sum;
  logic [bbt_pkg::BYTES_W:0]   byt_sum;
  logic [SUM_W-1:0]            tim_sum;

  always_comb begin
    gap  = (t > last_r)  ? (t - last_r)  : '0;
    span = (t > start_r) ? (t - start_r) : '0;
    restart = !open_r || (other_last > start_r) ||
              ({1'b0, gap} > {{(TIME_BITS - 31){1'b0}}, cfg.timeout});

    next_cnt   = {1'b0, pkts_r} + 1'b1;
    bytes_sum  = {1'b0, bytes_r} + {{(bbt_pkg::RUNB_W + 1 - bbt_pkg::LEN_W){1'b0}}, len};
    bytes_run  = bytes_sum[bbt_pkg::RUNB_W] ? '1 : bytes_sum[bbt_pkg::RUNB_W-1:0];
    at_bound   = (next_cnt == {1'b0, cfg.bound});
    past_bound = (next_cnt > {1'b0, cfg.bound});

    // on reaching the bound add the whole run so far, past it add this packet alone
    add_pkts  = at_bound ? next_cnt : {{bbt_pkg::PKT_W{1'b0}}, 1'b1};
    add_bytes = at_bound ? bytes_run
                         : {{(bbt_pkg::RUNB_W - bbt_pkg::LEN_W){1'b0}}, len};
    add_time  = at_bound ? span : gap;

    cnt_sum = {1'b0, tot_r.bulks} + 1'b1;
    pkt_sum = {1'b0, tot_r.packets} +
              {{(bbt_pkg::COUNT_W - bbt_pkg::PKT_W){1'b0}}, add_pkts};
    byt_sum = {1'b0, tot_r.bytes} +
              {{(bbt_pkg::BYTES_W + 1 - bbt_pkg::RUNB_W){1'b0}}, add_bytes};
    tim_sum = {{(SUM_W - bbt_pkg::TTIME_W){1'b0}}, tot_r.time_us} +
              {{(SUM_W - TIME_BITS){1'b0}}, add_time};

    open_nxt  = open_r;
    start_nxt = start_r;
    last_nxt  = last_r;
    pkts_nxt  = pkts_r;
    bytes_nxt = bytes_r;
    tot_nxt   = tot_r;

    if (upd) begin
      if (restart) begin
        open_nxt  = 1'b1;
        start_nxt = t;
        last_nxt  = t;
        pkts_nxt  = {{(bbt_pkg::PKT_W - 1){1'b0}}, 1'b1};
        bytes_nxt = {{(bbt_pkg::RUNB_W - bbt_pkg::LEN_W){1'b0}}, len};
      end else begin
        last_nxt  = t;
        bytes_nxt = bytes_run;
        pkts_nxt  = next_cnt[bbt_pkg::PKT_W] ? '1 : next_cnt[bbt_pkg::PKT_W-1:0];
        if (at_bound) begin
          tot_nxt.bulks = cnt_sum[bbt_pkg::COUNT_W] ? '1 : cnt_sum[bbt_pkg::COUNT_W-1:0];
        end
        if (at_bound || past_bound) begin
          tot_nxt.packets = pkt_sum[bbt_pkg::COUNT_W] ? '1 : pkt_sum[bbt_pkg::COUNT_W-1:0];
          tot_nxt.bytes   = byt_sum[bbt_pkg::BYTES_W] ? '1 : byt_sum[bbt_pkg::BYTES_W-1:0];
          tot_nxt.time_us = (tim_sum > {{(SUM_W - bbt_pkg::TTIME_W){1'b0}},
                                        {bbt_pkg::TTIME_W{1'b1}}})
                            ? '1 : tim_sum[bbt_pkg::TTIME_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      start_r <= '0;
      last_r  <= '0;
      pkts_r  <= '0;
      bytes_r <= '0;
      tot_r   <= '0;
    end else begin
      open_r  <= open_nxt;
      start_r <= start_nxt;
      last_r  <= last_nxt;
      pkts_r  <= pkts_nxt;
      bytes_r <= bytes_nxt;
      tot_r   <= tot_nxt;
    end
  end

  assign last_time = last_r;
  assign totals    = tot_r;

endmodule

[src/bulk_transfer_tracker.sv]
// Top level of the bulk transfer tracker for one bidirectional flow.
//
// Input beats carry one packet descriptor each: arrival time, direction and
// payload length. Every accepted beat produces exactly one output beat with
// the forward and backward bulk totals as they stand after that packet.
// Packets with zero payload still produce a beat, with unchanged totals.
//
// A beat is taken into an input register; when the output beat is empty or
// being read, compares and saturating adds update the run state and the
// totals registers, which drive out_tdata directly, and out_tvalid rises
// with them. A new beat is accepted every cycle while the receiver keeps up.
// When out_tready is low the output beat holds, one further beat waits in
// the input register, and in_tready falls.
//
// Synchronous active-low reset clears all runs and totals and loads the
// registers with a timeout of 1000000 us and a bound of four packets.
// Write the registers on the cfg port only while no beat is in flight.
module bulk_transfer_tracker #(
  parameter int TIME_BITS = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // time_us [TIME_BITS-1:0], payload_bytes [TIME_BITS+15:TIME_BITS], zero pad
  input  logic [((TIME_BITS + bbt_pkg::LEN_W + 7) / 8) * 8 - 1:0] in_tdata,
  // reverse
  input  logic                           in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // fwd_bulks, fwd_bulk_packets, fwd_bulk_bytes, fwd_bulk_time_us,
  // bwd_bulks, bwd_bulk_packets, bwd_bulk_bytes, bwd_bulk_time_us
  output logic [bbt_pkg::OUT_W-1:0]      out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [31:0]                    cfg_wdata
);

  logic                      item_valid;
  logic [TIME_BITS-1:0]      item_time;
  logic                      item_rev;
  logic [bbt_pkg::LEN_W-1:0] item_len;
  logic                      adv;
  logic                      load;
  logic                      out_valid_r, out_valid_nxt;
  bbt_pkg::bbt_cfg_t         cfg_r, cfg_nxt;
  logic [TIME_BITS-1:0]      fwd_last, bwd_last;
  bbt_pkg::bbt_totals_t      fwd_tot, bwd_tot;
  logic                      fwd_upd, bwd_upd;

  assign adv       = item_valid && (!out_valid_r || out_tready);
  assign in_tready = !item_valid || adv;
  assign load      = in_tvalid && in_tready;

  bbt_in_reg #(.TIME_BITS(TIME_BITS)) u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .drain   (adv),
    .time_in (in_tdata[TIME_BITS-1:0]),
    .rev_in  (in_tuser),
    .len_in  (in_tdata[TIME_BITS + bbt_pkg::LEN_W - 1:TIME_BITS]),
    .valid   (item_valid),
    .time_q  (item_time),
    .rev_q   (item_rev),
    .len_q   (item_len)
  );

  // zero payload changes nothing but still yields a beat
  assign fwd_upd = adv && !item_rev && (item_len != '0);
  assign bwd_upd = adv && item_rev && (item_len != '0);

  bbt_dir_track #(.TIME_BITS(TIME_BITS)) u_fwd (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (fwd_upd),
    .t          (item_time),
    .len        (item_len),
    .other_last (bwd_last),
    .cfg        (cfg_r),
    .last_time  (fwd_last),
    .totals     (fwd_tot)
  );

  bbt_dir_track #(.TIME_BITS(TIME_BITS)) u_bwd (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (bwd_upd),
    .t          (item_time),
    .len        (item_len),
    .other_last (fwd_last),
    .cfg        (cfg_r),
    .last_time  (bwd_last),
    .totals     (bwd_tot)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        bbt_pkg::CFG_TIMEOUT: cfg_nxt.timeout = cfg_wdata;
        bbt_pkg::CFG_BOUND:   cfg_nxt.bound   = cfg_wdata[7:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      cfg_r.timeout <= bbt_pkg::TIMEOUT_RST;
      cfg_r.bound   <= bbt_pkg::BOUND_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {bwd_tot, fwd_tot};

`ifndef SYNTHESIS
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while both stages are full");

  a_adv_shows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("updated totals not presented");

  a_hold_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_tdata))
    else $error("totals changed under a stalled output beat");

  a_fwd_order: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_tot.packets >= fwd_tot.bulks)
    else $error("forward bulk packets below bulk count");

  a_bwd_order: assert property (@(posedge clk) disable iff (!rst_n)
    bwd_tot.packets >= bwd_tot.bulks)
    else $error("backward bulk packets below bulk count");
`endif

endmodule

[bench/tb_bulk_transfer_tracker.sv]
// Self-checking bench for the bulk transfer tracker: directed rows, then random bursts.
module tb_bulk_transfer_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_TIME_BITS = 48;
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 400;

  localparam logic [63:0] CAP32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] CAP40 = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [63:0] CAP48 = 64'h0000_FFFF_FFFF_FFFF;

  typedef enum logic { DIR_FWD = 1'b0, DIR_BWD = 1'b1 } dir_t;
  typedef enum logic { ROW_PKT = 1'b0, ROW_CFG = 1'b1 } row_kind_t;

  // bwd totals in the upper half, as on out_tdata
  typedef struct packed {
    bbt_pkg::bbt_totals_t bwd;
    bbt_pkg::bbt_totals_t fwd;
  } flow_totals_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [47:0] stamp;
    dir_t        dir;
    logic [15:0] len;
    logic [31:0] tmo;
    logic [7:0]  bnd;
    logic        zero_due;
  } script_row_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  // time_us [47:0], payload_bytes [63:48]
  logic [63:0]       in_tdata   = '0;
  // reverse
  logic              in_tuser   = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  // fwd_bulks, fwd_bulk_packets, fwd_bulk_bytes, fwd_bulk_time_us,
  // bwd_bulks, bwd_bulk_packets, bwd_bulk_bytes, bwd_bulk_time_us
  logic [bbt_pkg::OUT_W-1:0] out_tdata;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic              cfg_we     = 1'b0;
  logic              cfg_addr   = bbt_pkg::CFG_TIMEOUT;
  logic [31:0]       cfg_wdata  = '0;

  bulk_transfer_tracker #(.TIME_BITS(TB_TIME_BITS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker copy: settings, open runs and per-direction totals
  logic [31:0] gap_limit_us;
  logic [7:0]  run_target;
  logic        run_live     [2];
  logic [47:0] run_first_us [2];
  logic [47:0] run_prev_us  [2];
  logic [7:0]  run_count    [2];
  logic [31:0] run_octets   [2];
  bbt_pkg::bbt_totals_t acc [2];

  flow_totals_t expected_totals [$];
  script_row_t  script [$];

  int          fault_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          holds_asked    = 0;
  int          holds_done     = 0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;
  logic [47:0] stamp_us       = '0;
  dir_t        dir_now        = DIR_FWD;
  int          burst_left     = 0;

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] cap);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, cap}) ? cap : s[63:0];
  endfunction

  function automatic logic [47:0] gap_us(input logic [47:0] later, input logic [47:0] earlier);
    return (later > earlier) ? later - earlier : '0;
  endfunction

  function automatic flow_totals_t apply_packet(input logic [47:0] t, input dir_t dir,
                                                input logic [15:0] len);
    int           d;
    int           o;
    logic [8:0]   nxt;
    logic         fresh;
    flow_totals_t snap;
    d = (dir == DIR_BWD) ? 1 : 0;
    o = 1 - d;
    if (len != '0) begin
      // opposite side only breaks the run when it sent strictly after the run began
      fresh = !run_live[d] || (run_prev_us[o] > run_first_us[d]) ||
              (gap_us(t, run_prev_us[d]) > {16'd0, gap_limit_us});
      if (fresh) begin
        run_live[d]     = 1'b1;
        run_first_us[d] = t;
        run_prev_us[d]  = t;
        run_count[d]    = 8'd1;
        run_octets[d]   = 32'(len);
      end else begin
        nxt = {1'b0, run_count[d]} + 9'd1;
        run_octets[d] = 32'(sat_sum(64'(run_octets[d]), 64'(len), CAP32));
        if (nxt == {1'b0, run_target}) begin
          acc[d].bulks   = 32'(sat_sum(64'(acc[d].bulks), 64'd1, CAP32));
          acc[d].packets = 32'(sat_sum(64'(acc[d].packets), 64'(nxt), CAP32));
          acc[d].bytes   = 40'(sat_sum(64'(acc[d].bytes), 64'(run_octets[d]), CAP40));
          acc[d].time_us = 48'(sat_sum(64'(acc[d].time_us),
                                       64'(gap_us(t, run_first_us[d])), CAP48));
        end else if (nxt > {1'b0, run_target}) begin
          acc[d].packets = 32'(sat_sum(64'(acc[d].packets), 64'd1, CAP32));
          acc[d].bytes   = 40'(sat_sum(64'(acc[d].bytes), 64'(len), CAP40));
          acc[d].time_us = 48'(sat_sum(64'(acc[d].time_us),
                                       64'(gap_us(t, run_prev_us[d])), CAP48));
        end
        // hold at 255 so a long run never counts its bulk twice
        run_count[d]   = (nxt > 9'd255) ? 8'd255 : nxt[7:0];
        run_prev_us[d] = t;
      end
    end
    snap.fwd = acc[0];
    snap.bwd = acc[1];
    return snap;
  endfunction

  task automatic compare_field(input string side, input string field,
                               input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch %s_%s: expected %0h, got %0h", side, field, want, got);
    end
  endtask

  task automatic send_packet(input logic [47:0] t, input dir_t dir, input logic [15:0] len,
                             input logic zero_due);
    flow_totals_t due;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {len, t};
    in_tuser  <= dir;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    due = apply_packet(t, dir, len);
    expected_totals.push_back(zero_due ? flow_totals_t'('0) : due);
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_totals.size() != 0) @(posedge clk);
  endtask

  // Both registers in consecutive cycles; upper bits of the bound write are junk
  task automatic load_settings(input logic [31:0] tmo, input logic [7:0] bnd);
    cfg_we    <= 1'b1;
    cfg_addr  <= bbt_pkg::CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    gap_limit_us = tmo;
    cfg_addr  <= bbt_pkg::CFG_BOUND;
    cfg_wdata <= {24'($urandom), bnd};
    @(posedge clk);
    run_target = bnd;
    cfg_we <= 1'b0;
  endtask

  task automatic pkt_row(input logic [47:0] t, input dir_t dir, input logic [15:0] len,
                         input logic zero_due);
    script.push_back('{ROW_PKT, t, dir, len, 32'd0, 8'd0, zero_due});
  endtask

  task automatic cfg_row(input logic [31:0] tmo, input logic [7:0] bnd);
    script.push_back('{ROW_CFG, 48'd0, DIR_FWD, 16'd0, tmo, bnd, 1'b0});
  endtask

  task automatic advance_stamp(input logic [31:0] tmo);
    int          r;
    logic [63:0] jump;
    r = $urandom_range(99);
    jump = '0;
    if (r < 12) jump = '0;
    else if (r < 62) jump = 64'($urandom_range(tmo));
    else if (r < 72) jump = 64'(tmo);
    else if (r < 80) jump = 64'(tmo) + 64'd1;
    else if (r < 85) jump = 64'(tmo) + 64'($urandom_range(1, 5000));
    else if (r < 92) jump = {$urandom, $urandom};
    else jump = -64'($urandom_range(1, 2000));
    stamp_us = stamp_us + jump[47:0];
  endtask

  task automatic run_phase(input int n, input logic [31:0] tmo, input logic [7:0] bnd,
                           input int tx_idle, input int rx_stall, input int steady,
                           input bit squeeze);
    logic [15:0] len;
    logic [63:0] anywhere;
    dir_t        dir;
    int          r;
    load_settings(tmo, bnd);
    send_idle_pct  = tx_idle;
    recv_stall_pct = rx_stall;
    burst_left     = 0;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 5) holds_asked++;
      if (squeeze && i == n / 2) pause_until_drained();
      r = $urandom_range(99);
      if (i < steady) begin
        // one unbroken forward run, well past the largest bound
        dir = DIR_FWD;
        stamp_us = stamp_us + 48'($urandom_range(1000));
      end else if (r < 5) begin
        anywhere = {$urandom, $urandom};
        stamp_us = anywhere[47:0];
        dir = dir_t'($urandom_range(1));
      end else begin
        if (burst_left == 0) begin
          dir_now    = dir_t'($urandom_range(1));
          burst_left = $urandom_range(1, int'(bnd) + 3);
        end
        burst_left--;
        dir = dir_now;
        advance_stamp(tmo);
      end
      r = $urandom_range(99);
      if (r < 8) len = '0;
      else if (r < 14) len = 16'hFFFF;
      else if (r < 18) len = 16'd1;
      else len = 16'($urandom_range(1, 65535));
      send_packet(stamp_us, dir, len, 1'b0);
    end
    pause_until_drained();
  endtask

  always @(posedge clk) begin : result_side
    flow_totals_t         want;
    flow_totals_t         got;
    bbt_pkg::bbt_totals_t w_side;
    bbt_pkg::bbt_totals_t g_side;
    string                side;
    int                   k;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_totals.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("result beat with nothing expected: %h", out_tdata);
      end else begin
        want = expected_totals.pop_front();
        got  = out_tdata;
        for (k = 0; k < 2; k++) begin
          w_side = (k == 1) ? want.bwd : want.fwd;
          g_side = (k == 1) ? got.bwd : got.fwd;
          side   = (k == 1) ? "bwd" : "fwd";
          compare_field(side, "bulks", 64'(w_side.bulks), 64'(g_side.bulks));
          compare_field(side, "bulk_packets", 64'(w_side.packets), 64'(g_side.packets));
          compare_field(side, "bulk_bytes", 64'(w_side.bytes), 64'(g_side.bytes));
          compare_field(side, "bulk_time_us", 64'(w_side.time_us), 64'(g_side.time_us));
        end
      end
    end
    if (holds_done != holds_asked) begin
      hold_left = LONG_HOLD;
      holds_done++;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("tb_bulk_transfer_tracker NOT OK");
        $finish;
      end
    end
  end

  initial begin
    gap_limit_us = bbt_pkg::TIMEOUT_RST;
    run_target   = bbt_pkg::BOUND_RST;
    for (int d = 0; d < 2; d++) begin
      run_live[d]     = 1'b0;
      run_first_us[d] = '0;
      run_prev_us[d]  = '0;
      run_count[d]    = '0;
      run_octets[d]   = '0;
      acc[d]          = '0;
    end

    // empty payload, first packets, opposite-side break and equal-time keep
    pkt_row(48'd0,       DIR_FWD, 16'd0,     1'b1);
    pkt_row(48'd0,       DIR_FWD, 16'd1,     1'b1);
    pkt_row(48'd10,      DIR_FWD, 16'hFFFF,  1'b1);
    pkt_row(48'd20,      DIR_BWD, 16'd100,   1'b1);
    pkt_row(48'd100,     DIR_FWD, 16'd9,     1'b1);
    pkt_row(48'd100,     DIR_BWD, 16'd11,    1'b1);
    pkt_row(48'd100,     DIR_FWD, 16'd13,    1'b0);
    pkt_row(48'd101,     DIR_FWD, 16'd17,    1'b0);
    pkt_row(48'd102,     DIR_FWD, 16'd19,    1'b0);
    // time running backwards, gap just over and exactly at the timeout
    pkt_row(48'd50,      DIR_FWD, 16'd23,    1'b0);
    pkt_row(48'd1000051, DIR_FWD, 16'd29,    1'b0);
    pkt_row(48'd2000051, DIR_FWD, 16'd31,    1'b0);
    pkt_row(48'd2000051, DIR_BWD, 16'd0,     1'b0);
    // zero timeout: only a zero gap keeps the run
    cfg_row(32'd0, 8'd4);
    pkt_row(48'd2000051, DIR_FWD, 16'd1,     1'b0);
    pkt_row(48'd2000052, DIR_FWD, 16'd1,     1'b0);
    // bound below two never counts a bulk
    cfg_row(32'd1000000, 8'd1);
    pkt_row(48'd2000053, DIR_FWD, 16'd3,     1'b0);
    pkt_row(48'd2000060, DIR_FWD, 16'd5,     1'b0);
    // widest settings, largest time, then wrap to zero
    cfg_row(32'hFFFF_FFFF, 8'd255);
    pkt_row(48'd2000060, DIR_BWD, 16'd7,     1'b0);
    pkt_row(48'hFFFF_FFFF_FFFF, DIR_BWD, 16'hFFFF, 1'b0);
    pkt_row(48'd0,       DIR_FWD, 16'hFFFF,  1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        pause_until_drained();
        load_settings(script[i].tmo, script[i].bnd);
      end else begin
        send_packet(script[i].stamp, script[i].dir, script[i].len, script[i].zero_due);
      end
    end
    pause_until_drained();

    stamp_us = '0;
    run_phase(350, 32'd1000,      8'd4,   0,  0,  0,   1'b0);
    run_phase(300, 32'd1,         8'd2,   84, 0,  0,   1'b0);
    run_phase(380, 32'hFFFF_FFFF, 8'd255, 0,  84, 300, 1'b0);
    run_phase(300, 32'd50,        8'd0,   35, 35, 0,   1'b0);
    run_phase(300, 32'($urandom_range(1, 5000)), 8'($urandom_range(2, 16)),
              0, 0, 0, 1'b1);
    run_phase(300, 32'd0,         8'd3,   35, 35, 0,   1'b0);

    repeat (10) @(posedge clk);
    if (fault_count == 0 && expected_totals.size() == 0) begin
      $display("tb_bulk_transfer_tracker OK");
    end else begin
      $display("tb_bulk_transfer_tracker NOT OK");
    end
    $finish;
  end

endmodule
